/* rtl/mrr_pkg.sv */
// Package for the Modbus RTU reply receiver: item types, status codes,
// register indexes and the CRC-16 byte update.
// No dependencies.
package mrr_pkg;

  // Frame status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXCEPTION = 2'd1,
    ST_SHORT     = 2'd2,
    ST_CRC_BAD   = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SLAVE_ADDR = 2'd0,
    CFG_REG_COUNT  = 2'd1,
    CFG_BUF_LIMIT  = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  FUNC_EXC_MASK = 8'h80;
  localparam logic [7:0]  MIN_FRAME_LEN = 8'd7;
  localparam logic [7:0]  EXC_FRAME_LEN = 8'd3;
  localparam logic [7:0]  FRAME_OVERHEAD = 8'd5;

  // Input item
  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       frame_done;
    status_e    status;
    logic [7:0] exception_code;
    logic [7:0] frame_length;
  } out_item_t;

  // One byte through the reflected CRC-16, unrolled over eight bit steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  // Status of a frame that ends without an exception
  function automatic status_e end_status(input logic [7:0]  count,
                                         input logic [15:0] tail,
                                         input logic [15:0] crc);
    status_e st;
    if (count < MIN_FRAME_LEN) begin
      st = ST_SHORT;
    end else if ({tail[7:0], tail[15:8]} == crc) begin
      st = ST_OK;
    end else begin
      st = ST_CRC_BAD;
    end
    return st;
  endfunction

endpackage

/* rtl/mrr_stream_if.sv */
// Valid/ready stream channel carrying one item of a given payload type.
// Payload types come from mrr_pkg where used.
interface mrr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/modbus_rtu_response_receiver_unit.sv */
// Modbus RTU reply receiver: address hunt, byte pass-through, exception,
// length and CRC-16 frame check. Depends on mrr_pkg and mrr_stream_if.
//
//  channel  | dir | payload     | notes
//  ---------+-----+-------------+-----------------------------------------
//  in_i     | in  | in_item_t   | received byte or line-idle event
//  out_o    | out | out_item_t  | stored byte and/or end-of-frame status
//  cfg_*    | in  | 8-bit data  | slave address, register count, limit
//
// One item a cycle: each item is decoded, CRC-updated and checked in the
// cycle it is taken, and its result sits in the output register next cycle.
// Input is taken whenever the output register is empty or being drained,
// so a stalled sink holds at most one result and stalls the input with it.
// Reset clears frame state to hunting and loads the register defaults.
module modbus_rtu_response_receiver_unit
  import mrr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  mrr_stream_if.sink          in_i,
  mrr_stream_if.source        out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // Configuration registers
  logic [7:0] slave_addr_q;
  logic [6:0] reg_count_q;
  logic [7:0] buf_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 8'd1;
      reg_count_q  <= 7'd2;
      buf_limit_q  <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLAVE_ADDR: slave_addr_q <= cfg_wdata_i;
        CFG_REG_COUNT:  reg_count_q  <= cfg_wdata_i[6:0];
        CFG_BUF_LIMIT:  buf_limit_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Frame length limit: min((count * 2 + 5) mod 256, buffer limit)
  logic [7:0] wanted_len;
  logic [7:0] limit;
  assign wanted_len = {reg_count_q, 1'b0} + FRAME_OVERHEAD;
  assign limit      = (wanted_len < buf_limit_q) ? wanted_len : buf_limit_q;

  // Frame state
  logic [7:0]  count_q, count_d;
  logic [7:0]  func_q, func_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] tail_q, tail_d;

  // Output register
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res;
  logic      res_valid;
  logic      in_fire;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // Per-item decode
  logic [7:0]  rx_b;
  logic [7:0]  cnt_new;
  logic [15:0] crc_new;
  logic [15:0] tail_new;
  logic        hunt;

  always_comb begin
    rx_b      = in_i.payload.rx_byte;
    cnt_new   = count_q + 8'd1;
    crc_new   = (count_q >= 8'd2) ? crc_feed(crc_q, tail_q[15:8]) : crc_q;
    tail_new  = {tail_q[7:0], rx_b};
    count_d   = count_q;
    func_d    = func_q;
    crc_d     = crc_q;
    tail_d    = tail_q;
    res       = '0;
    res_valid = 1'b0;
    hunt      = 1'b0;

    if (in_fire) begin
      if (in_i.payload.action) begin
        // line idle ends a frame in progress
        if (count_q != 8'd0) begin
          res_valid        = 1'b1;
          res.frame_done   = 1'b1;
          res.status       = end_status(count_q, tail_q, crc_q);
          res.frame_length = count_q;
          hunt             = 1'b1;
        end
      end else if (count_q >= limit) begin
        // byte while full: dropped, frame closes with what is stored
        res_valid        = 1'b1;
        res.frame_done   = 1'b1;
        res.status       = end_status(count_q, tail_q, crc_q);
        res.frame_length = count_q;
        hunt             = 1'b1;
      end else if (count_q != 8'd0 || rx_b == slave_addr_q) begin
        // store and pass the byte on
        count_d        = cnt_new;
        crc_d          = crc_new;
        tail_d         = tail_new;
        if (count_q == 8'd1) begin
          func_d = rx_b;
        end
        res_valid      = 1'b1;
        res.byte_valid = 1'b1;
        res.data_byte  = rx_b;
        res.byte_index = count_q;
        if (cnt_new == EXC_FRAME_LEN && (func_q & FUNC_EXC_MASK) != 8'h00) begin
          res.frame_done     = 1'b1;
          res.status         = ST_EXCEPTION;
          res.exception_code = rx_b;
          res.frame_length   = EXC_FRAME_LEN;
          hunt               = 1'b1;
        end else if (cnt_new >= limit) begin
          res.frame_done   = 1'b1;
          res.status       = end_status(cnt_new, tail_new, crc_new);
          res.frame_length = cnt_new;
          hunt             = 1'b1;
        end
      end
    end

    if (hunt) begin
      count_d = 8'd0;
      func_d  = 8'd0;
      crc_d   = CRC_INIT;
      tail_d  = 16'd0;
    end
  end

  // Frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 8'd0;
      func_q  <= 8'd0;
      crc_q   <= CRC_INIT;
      tail_q  <= 16'd0;
    end else begin
      count_q <= count_d;
      func_q  <= func_d;
      crc_q   <= crc_d;
      tail_q  <= tail_d;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule
